FILE: hdl/pls_pkg.sv
// package: constants, codes and helpers for the positional list store
`timescale 1ns / 1ps
package pls_pkg;
    localparam int CAPACITY_DEF = 32;
    localparam int MAX_RUN      = 32;
    localparam int MODE_W       = 3;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int STAT_W       = 2;
    localparam int LEN_W        = 6;

    localparam logic [MODE_W-1:0] MODE_INS_FIRST = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_LAST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_LAST  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] element;
        logic [LEN_W-1:0]         length;
        logic                     last_of_run;
    } t_rsp;
endpackage

FILE: hdl/pls_if.sv
// valid/ready channel interface carrying one word
`timescale 1ns / 1ps
interface pls_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/positional_list_store.sv
// positional list store: top level with ram-based shift sequencer
// a request that changes nothing goes from acceptance through S_OUT, which presents its result
// insert: reads and writes back (read, write back) each slot from the end down to the target,
// then presents through S_OUT; delete: reads and writes back each slot from the target to the end
// a dump reads each word, then presents it once the output is not stalled
// one request at a time, next accepted once the result is taken; reset clears state, occupancy and valids, not the ram
`timescale 1ns / 1ps
module positional_list_store #(
    parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pls_if.sink   i_req,
    pls_if.source o_rsp
);
    import pls_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int RUN_LIM = (CAPACITY < MAX_RUN) ? CAPACITY : MAX_RUN;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_DUMP = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]               r_state;
    logic [CW-1:0]            r_occ;
    logic [CW-1:0]            r_idx;   // current slot being moved / read
    logic [CW-1:0]            r_tgt;   // edited slot
    logic                     r_ins;
    logic signed [DATA_W-1:0] r_val;
    logic                     r_ovalid;
    t_rsp                     r_rsp;
    logic                     r_dvalid; // dump read pending in ram output

    logic                     we;
    logic [AW-1:0]            waddr, raddr;
    logic [DATA_W-1:0]        wdata, rdata;

    pls_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [PW-1:0] pos_w, occ_w;
    assign pos_w = PW'(i_req.data.position);
    assign occ_w = PW'(r_occ);

    assign i_req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    logic acc;
    assign acc = i_req.valid && i_req.ready;

    logic [CW-1:0] run_n;
    assign run_n = (r_occ < CW'(RUN_LIM)) ? r_occ : CW'(RUN_LIM);

    // ram control
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = r_val;
        raddr = '0;
        case (r_state)
            S_RD: begin
                if (r_ins) begin
                    if (r_idx > r_tgt) raddr = AW'(r_idx - CW'(1));
                end else begin
                    raddr = AW'(r_idx + CW'(1));
                end
            end
            S_WR: begin
                we = 1'b1;
                if (r_ins) begin
                    waddr = AW'(r_idx);
                    wdata = (r_idx > r_tgt) ? rdata : r_val;
                end else begin
                    waddr = AW'(r_idx);
                    wdata = rdata;
                end
            end
            S_DUMP: raddr = AW'(r_idx);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_occ    <= '0;
            r_ovalid <= 1'b0;
            r_dvalid <= 1'b0;
        end else begin
            if (o_rsp.valid && o_rsp.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_val <= i_req.data.value;
                        r_rsp.element     <= '0;
                        r_rsp.last_of_run <= 1'b1;
                        r_rsp.status      <= ST_OK;
                        r_state           <= S_OUT;
                        case (i_req.data.mode)
                            MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_POS: begin
                                if (r_occ >= CW'(CAPACITY)) begin
                                    r_rsp.status <= ST_FULL;
                                end else if (i_req.data.mode == MODE_INS_POS &&
                                             (pos_w == '0 || pos_w > occ_w + PW'(1))) begin
                                    r_rsp.status <= ST_BADPOS;
                                end else begin
                                    r_ins   <= 1'b1;
                                    r_idx   <= r_occ;
                                    r_state <= S_RD;
                                    if (i_req.data.mode == MODE_INS_FIRST)
                                        r_tgt <= '0;
                                    else if (i_req.data.mode == MODE_INS_LAST)
                                        r_tgt <= r_occ;
                                    else
                                        r_tgt <= CW'(pos_w - PW'(1));
                                end
                            end
                            MODE_DEL_POS, MODE_DEL_FIRST, MODE_DEL_LAST: begin
                                if (r_occ == '0) begin
                                    r_rsp.status <= ST_EMPTY;
                                end else if (i_req.data.mode == MODE_DEL_POS &&
                                             (pos_w == '0 || pos_w > occ_w)) begin
                                    r_rsp.status <= ST_BADPOS;
                                end else begin
                                    r_ins <= 1'b0;
                                    if (i_req.data.mode == MODE_DEL_FIRST)
                                        r_idx <= '0;
                                    else if (i_req.data.mode == MODE_DEL_LAST)
                                        r_idx <= r_occ - CW'(1);
                                    else
                                        r_idx <= CW'(pos_w - PW'(1));
                                    r_state <= S_RD;
                                end
                            end
                            MODE_DUMP: begin
                                if (r_occ == '0) begin
                                    r_rsp.status <= ST_EMPTY;
                                end else begin
                                    r_idx   <= '0;
                                    r_state <= S_DUMP;
                                end
                            end
                            default: ;
                        endcase
                        r_rsp.length <= LEN_W'(r_occ);
                    end
                end
                S_RD: begin
                    // deletes stop when the moved slot is the last one
                    if (!r_ins && r_idx + CW'(1) >= r_occ) begin
                        r_occ        <= r_occ - CW'(1);
                        r_rsp.length <= LEN_W'(r_occ - CW'(1));
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_ins) begin
                        if (r_idx == r_tgt) begin
                            r_occ        <= r_occ + CW'(1);
                            r_rsp.length <= LEN_W'(r_occ + CW'(1));
                            r_state      <= S_OUT;
                        end else begin
                            r_idx   <= r_idx - CW'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_RD;
                    end
                end
                S_DUMP: begin
                    // issue reads; present each word when the output is free
                    if (!r_dvalid) begin
                        r_dvalid <= 1'b1;
                    end else if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid          <= 1'b1;
                        r_rsp.status      <= ST_OK;
                        r_rsp.element     <= rdata;
                        r_rsp.length      <= LEN_W'(r_occ);
                        r_rsp.last_of_run <= (r_idx + CW'(1) == run_n);
                        r_dvalid          <= 1'b0;
                        if (r_idx + CW'(1) == run_n) r_state <= S_IDLE;
                        else r_idx <= r_idx + CW'(1);
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(CAPACITY)) else $error("occupancy above capacity");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_req.ready) else $error("accept while busy");
    a_occ_stable_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> $stable(r_occ)) else $error("dump changed occupancy");
`endif
endmodule

FILE: hdl/pls_ram.sv
// generic single-port-write, single-read ram with registered read
`timescale 1ns / 1ps
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
